// ===== design/assert_macros.svh =====
// assertion macros shared by the color table classifier rtl
// no dependencies; included by the files that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock, off while reset is high
`define CTH_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define CTH_ASSERT_NEXT(lbl, clk_s, rst_s, cond, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (cons)) else $error(msg);

`endif

// ===== design/cth_pkg.sv =====
// shared types and constants of the color table pixel classifier
// no dependencies; imported by every module of the block
package cth_pkg;

  localparam int BLOCK_SIZE        = 8;
  localparam int HUE_BITS          = 8;
  localparam int SAT_BITS          = 8;
  localparam int MAX_BLOCK_COLUMNS = 256;

  localparam int PIX_W       = 8;
  localparam int COUNTER_DEPTH = 256;
  localparam int CNT_IDX_W   = 8;
  localparam int CNT_W       = 8;
  localparam int COUNT_MAX   = 255;
  localparam int BLOCK_HALF  = BLOCK_SIZE * BLOCK_SIZE / 2;
  localparam int COL_W       = 11;
  localparam int FW_W        = 12;
  localparam int WIDTH_LIMIT = 2048;
  localparam int RIG_W       = 4;
  localparam int CIB_W       = 4;
  localparam int COL_LIMIT   = (MAX_BLOCK_COLUMNS < COUNTER_DEPTH) ?
                               MAX_BLOCK_COLUMNS : COUNTER_DEPTH;

  localparam int TBL_ROWS = 1 << HUE_BITS;
  localparam int TBL_COLS = 1 << SAT_BITS;

  localparam int OPQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd2;

  // classified pixel handed from front to back
  typedef struct packed {
    logic                 match;
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic                 usable;
    logic                 emit;
    logic [CNT_IDX_W-1:0] bcol;
    logic                 sof;
  } op_t;

  // one result transaction
  typedef struct packed {
    logic                 is_match;
    logic [PIX_W-1:0]     out_red;
    logic [PIX_W-1:0]     out_green;
    logic [PIX_W-1:0]     out_blue;
    logic                 block_valid;
    logic                 block_set;
    logic [CNT_IDX_W-1:0] block_column;
  } res_t;

endpackage

// ===== design/cth_front.sv =====
// front end: config registers, pixel position tracking and the color table
// depends on cth_pkg and assert_macros.svh
`include "assert_macros.svh"

module cth_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cth_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [cth_pkg::PIX_W-1:0]      hue,
  input  logic [cth_pkg::PIX_W-1:0]      saturation,
  input  logic [cth_pkg::PIX_W-1:0]      brightness,
  input  logic [cth_pkg::PIX_W-1:0]      red,
  input  logic [cth_pkg::PIX_W-1:0]      green,
  input  logic [cth_pkg::PIX_W-1:0]      blue,
  input  logic                          start_of_frame,
  input  logic                          final_row,
  input  logic                          q_full,
  output logic                          q_push,
  output cth_pkg::op_t                   q_op
);
  import cth_pkg::*;

  logic [PIX_W-1:0] intensity_min;
  logic [PIX_W-1:0] intensity_max;
  logic [FW_W-1:0]  frame_width;

  logic                clr_busy;
  logic [HUE_BITS-1:0] clr_row;

  logic [COL_W-1:0] pixel_column;
  logic [CIB_W-1:0] col_in_block;
  logic [COL_W-1:0] block_col;
  logic [RIG_W-1:0] row_in_group;

  logic [TBL_COLS-1:0] color_table [TBL_ROWS];

  logic                f_valid;
  op_t                 f_op;
  logic [TBL_COLS-1:0] f_row;
  logic [SAT_BITS-1:0] f_sat;

  logic                accept;
  logic                classify;
  logic                in_win;
  logic [HUE_BITS-1:0] hue_row;
  logic [SAT_BITS-1:0] sat_col;
  logic [FW_W-1:0]     eff_width;
  logic [COL_W-1:0]    cur_pc;
  logic [CIB_W-1:0]    cur_cib;
  logic [COL_W-1:0]    cur_bcol;
  logic [RIG_W-1:0]    cur_rig;
  logic [FW_W-1:0]     pc_plus;
  logic                row_end;
  logic                cib_last;
  logic                blk_col_end;
  logic                blk_row_end;
  logic                usable;
  logic                f_adv;

  assign full     = clr_busy || (f_valid && q_full);
  assign accept   = push && !full;
  assign classify = !action;
  assign f_adv    = f_valid && !q_full;

  assign in_win  = (brightness >= intensity_min) && (brightness <= intensity_max);
  assign hue_row = hue[PIX_W-1 -: HUE_BITS];
  assign sat_col = saturation[PIX_W-1 -: SAT_BITS];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_min <= '0;
      intensity_max <= PIX_W'(COUNT_MAX);
      frame_width   <= FW_W'(640);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INTENSITY_MIN: intensity_min <= cfg_data[PIX_W-1:0];
        REG_INTENSITY_MAX: intensity_max <= cfg_data[PIX_W-1:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[FW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_width = frame_width;
    if (frame_width == '0) begin
      eff_width = FW_W'(1);
    end else if (frame_width > FW_W'(WIDTH_LIMIT)) begin
      eff_width = FW_W'(WIDTH_LIMIT);
    end
  end

  // position of the current pixel, start of frame restarts it
  assign cur_pc   = start_of_frame ? '0 : pixel_column;
  assign cur_cib  = start_of_frame ? '0 : col_in_block;
  assign cur_bcol = start_of_frame ? '0 : block_col;
  assign cur_rig  = start_of_frame ? '0 : row_in_group;

  assign pc_plus     = {1'b0, cur_pc} + FW_W'(1);
  assign row_end     = pc_plus >= eff_width;
  assign cib_last    = cur_cib == CIB_W'(BLOCK_SIZE - 1);
  assign blk_col_end = cib_last || row_end;
  assign blk_row_end = (cur_rig >= RIG_W'(BLOCK_SIZE - 1)) || final_row;
  assign usable      = {1'b0, cur_bcol} < FW_W'(COL_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      col_in_block <= '0;
      block_col    <= '0;
      row_in_group <= '0;
    end else if (accept && classify) begin
      if (row_end) begin
        pixel_column <= '0;
        col_in_block <= '0;
        block_col    <= '0;
        row_in_group <= blk_row_end ? '0 : cur_rig + RIG_W'(1);
      end else begin
        pixel_column <= pc_plus[COL_W-1:0];
        col_in_block <= cib_last ? '0 : cur_cib + CIB_W'(1);
        block_col    <= cib_last ? cur_bcol + COL_W'(1) : cur_bcol;
        row_in_group <= cur_rig;
      end
    end
  end

  // clearing pass over the table rows after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      clr_row <= clr_row + HUE_BITS'(1);
      if (clr_row == HUE_BITS'(TBL_ROWS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // table: one row write or bit set, one registered row read
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      color_table[clr_row] <= '0;
    end else if (accept && action && in_win) begin
      color_table[hue_row][sat_col] <= 1'b1;
    end
    if (accept) begin
      f_row <= color_table[hue_row];
    end
  end

  // classify stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (f_adv) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_sat        <= sat_col;
      f_op.match   <= classify && in_win;
      f_op.red     <= red;
      f_op.green   <= green;
      f_op.blue    <= blue;
      f_op.usable  <= classify && usable;
      f_op.emit    <= classify && usable && blk_col_end && blk_row_end;
      f_op.bcol    <= cur_bcol[CNT_IDX_W-1:0];
      f_op.sof     <= classify && start_of_frame;
    end
  end

  always_comb begin
    q_op       = f_op;
    q_op.match = f_op.match && f_row[f_sat];
  end
  assign q_push = f_adv;

  `CTH_ASSERT_NEXT(a_front_hold, clk, rst, f_valid && q_full, f_valid, "front item lost while queue full")
  `CTH_ASSERT(a_front_clear, clk, rst, !(clr_busy && f_valid), "front busy during table clear")

endmodule

// ===== design/cth_opq.sv =====
// short queue of classified pixels between front and back
// depends on cth_pkg and assert_macros.svh
`include "assert_macros.svh"

module cth_opq (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  cth_pkg::op_t wr_op,
  output logic         q_full,
  input  logic         rd,
  output logic         rd_valid,
  output cth_pkg::op_t rd_op
);
  import cth_pkg::*;

  localparam int PTR_W = $clog2(OPQ_DEPTH);
  localparam int CNT_QW = $clog2(OPQ_DEPTH + 1);

  op_t              slots [OPQ_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_QW-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full   = count == CNT_QW'(OPQ_DEPTH);
  assign rd_valid = count != '0;
  assign rd_op    = slots[rp];
  assign do_wr    = wr && !q_full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (do_rd) begin
        rp <= (rp == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_QW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

  `CTH_ASSERT(a_opq_count, clk, rst, count <= CNT_QW'(OPQ_DEPTH), "op queue overfilled")

endmodule

// ===== design/cth_back.sv =====
// back end: per block column match counters and the result queue
// depends on cth_pkg and assert_macros.svh
`include "assert_macros.svh"

module cth_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cth_pkg::op_t  q_op,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output cth_pkg::res_t head
);
  import cth_pkg::*;

  localparam int OPTR_W = $clog2(OUTQ_DEPTH);
  localparam int OCNT_W = $clog2(OUTQ_DEPTH + 1);

  logic [CNT_W-1:0]         cnt_mem [COUNTER_DEPTH];
  logic [COUNTER_DEPTH-1:0] cnt_vld;

  logic             b_valid;
  op_t              b_op;
  logic [CNT_W-1:0] b_rd;
  logic             b_rd_ok;

  logic                 byp_valid;
  logic [CNT_IDX_W-1:0] byp_bcol;
  logic [CNT_W-1:0]     byp_val;

  res_t              oq [OUTQ_DEPTH];
  logic [OPTR_W-1:0] oq_wp;
  logic [OPTR_W-1:0] oq_rp;
  logic [OCNT_W-1:0] oq_cnt;

  logic             take;
  logic             b_adv;
  logic             b_wr;
  logic             out_space;
  logic             do_pop;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] cnt1;
  logic [CNT_W-1:0] new_count;
  res_t             b_res;

  assign out_space = oq_cnt != OCNT_W'(OUTQ_DEPTH);
  assign b_adv     = b_valid && out_space;
  assign take      = q_valid && (!b_valid || b_adv);
  assign q_pop     = take;
  assign b_wr      = b_adv && b_op.usable && (b_op.match || b_op.emit);

  // count as of now: last write may have raced this item's read
  always_comb begin
    if (byp_valid && byp_bcol == b_op.bcol) begin
      cur = byp_val;
    end else if (b_rd_ok) begin
      cur = b_rd;
    end else begin
      cur = '0;
    end
    cnt1 = (b_op.match && cur != CNT_W'(COUNT_MAX)) ? cur + CNT_W'(1) : cur;
    new_count = b_op.emit ? '0 : cnt1;
  end

  always_comb begin
    b_res.is_match     = b_op.match;
    b_res.out_red      = b_op.match ? b_op.red : '0;
    b_res.out_green    = b_op.match ? b_op.green : '0;
    b_res.out_blue     = b_op.match ? b_op.blue : '0;
    b_res.block_valid  = b_op.emit;
    b_res.block_set    = b_op.emit && (cnt1 > CNT_W'(BLOCK_HALF));
    b_res.block_column = b_op.emit ? b_op.bcol : '0;
  end

  // counter memory, read on take and written as the item leaves
  always_ff @(posedge clk) begin
    if (take) begin
      b_rd <= cnt_mem[q_op.bcol];
    end
    if (b_wr) begin
      cnt_mem[b_op.bcol] <= new_count;
    end
  end

  // entry valid bits, start of frame clears all after the older write
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (take && q_op.sof) begin
      cnt_vld <= '0;
    end else if (b_wr) begin
      cnt_vld[b_op.bcol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      byp_valid <= 1'b0;
    end else begin
      if (take) begin
        b_valid   <= 1'b1;
        byp_valid <= b_wr && !q_op.sof;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_op     <= q_op;
      b_rd_ok  <= cnt_vld[q_op.bcol] && !q_op.sof;
      byp_bcol <= b_op.bcol;
      byp_val  <= new_count;
    end
  end

  // result queue
  assign empty  = oq_cnt == '0;
  assign do_pop = pop && !empty;
  assign head   = oq[oq_rp];

  always_ff @(posedge clk) begin
    if (b_adv) begin
      oq[oq_wp] <= b_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= '0;
      oq_rp  <= '0;
      oq_cnt <= '0;
    end else begin
      if (b_adv) begin
        oq_wp <= (oq_wp == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_wp + OPTR_W'(1);
      end
      if (do_pop) begin
        oq_rp <= (oq_rp == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_rp + OPTR_W'(1);
      end
      if (b_adv && !do_pop) begin
        oq_cnt <= oq_cnt + OCNT_W'(1);
      end else if (do_pop && !b_adv) begin
        oq_cnt <= oq_cnt - OCNT_W'(1);
      end
    end
  end

  `CTH_ASSERT_NEXT(a_back_sof, clk, rst, take && q_op.sof, cnt_vld == '0, "counters not cleared at frame start")
  `CTH_ASSERT(a_back_oq, clk, rst, oq_cnt <= OCNT_W'(OUTQ_DEPTH), "result queue overfilled")

endmodule

// ===== design/color_table_pixel_classifier_top.sv =====
// top level of the color table pixel classifier
// depends on cth_pkg, cth_front, cth_opq and cth_back
//
//   channel   handshake              transaction
//   pixel     push / full            action, hsv and rgb bytes, frame marks
//   result    empty / pop            match flag, masked rgb, block decision
//   config    cfg_write (no wait)    register index and data
//
// one pixel per cycle while full stays low; a pixel reaches the result queue
// through the table row read, a queue slot and the counter read-modify-write
// after reset, full stays high while the table rows are cleared
// otherwise full rises only when the result side backs up and fills the queues
// the user must write config only while the block is idle; it is not enforced
module color_table_pixel_classifier_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cth_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [cth_pkg::PIX_W-1:0]      hue,
  input  logic [cth_pkg::PIX_W-1:0]      saturation,
  input  logic [cth_pkg::PIX_W-1:0]      brightness,
  input  logic [cth_pkg::PIX_W-1:0]      red,
  input  logic [cth_pkg::PIX_W-1:0]      green,
  input  logic [cth_pkg::PIX_W-1:0]      blue,
  input  logic                          start_of_frame,
  input  logic                          final_row,
  output logic                          empty,
  input  logic                          pop,
  output logic                          is_match,
  output logic [cth_pkg::PIX_W-1:0]      out_red,
  output logic [cth_pkg::PIX_W-1:0]      out_green,
  output logic [cth_pkg::PIX_W-1:0]      out_blue,
  output logic                          block_valid,
  output logic                          block_set,
  output logic [cth_pkg::CNT_IDX_W-1:0]  block_column
);
  import cth_pkg::*;

  // front to queue
  logic q_push;
  logic q_full;
  op_t  f_op;

  // queue to back
  logic q_valid;
  logic q_pop;
  op_t  q_op;

  res_t head;

  // front: window check, table train and lookup, pixel position
  cth_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .action         (action),
    .hue            (hue),
    .saturation     (saturation),
    .brightness     (brightness),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .start_of_frame (start_of_frame),
    .final_row      (final_row),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (f_op)
  );

  // decouples the table side from the counter side
  cth_opq u_opq (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_op    (f_op),
    .q_full   (q_full),
    .rd       (q_pop),
    .rd_valid (q_valid),
    .rd_op    (q_op)
  );

  // back: block counters, decisions and the result queue
  cth_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  // oldest result sits on the ports while empty is low
  assign is_match     = head.is_match;
  assign out_red      = head.out_red;
  assign out_green    = head.out_green;
  assign out_blue     = head.out_blue;
  assign block_valid  = head.block_valid;
  assign block_set    = head.block_set;
  assign block_column = head.block_column;

endmodule

// ===== test/tb_color_table_pixel_classifier_top.sv =====
// testbench of color_table_pixel_classifier_top: pixel streams checked against a
// behavioral classifier kept in this file; depends on cth_pkg and the design sources
`timescale 1ns / 100ps

module tb_color_table_pixel_classifier_top;
  import cth_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int TOTAL_ITEMS   = 1150;
  localparam int TAIL_ITEMS    = 100;     // last stretch, both sides run flat out
  localparam int PHASE_ITEMS   = 80;
  localparam int HOLD_CYCLES   = 300;     // long result-side hold-off
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;       // settle margin once every expected result is back
  localparam int DRAIN_CYCLES  = 16;
  localparam int REPORT_LIMIT  = 10;
  localparam int POOL_SIZE     = 16;
  localparam int DEFAULT_WIDTH = 640;
  localparam int TABLE_SIZE    = TBL_ROWS * TBL_COLS;

  typedef enum logic {
    ACT_CLASSIFY = 1'b0,
    ACT_TRAIN    = 1'b1
  } action_e;

  // one pixel transaction as it goes into the block
  typedef struct packed {
    action_e          action;
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] bright;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             sof;
    logic             last_row;
  } pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  logic                  action;
  logic [PIX_W-1:0]      hue;
  logic [PIX_W-1:0]      saturation;
  logic [PIX_W-1:0]      brightness;
  logic [PIX_W-1:0]      red;
  logic [PIX_W-1:0]      green;
  logic [PIX_W-1:0]      blue;
  logic                  start_of_frame;
  logic                  final_row;
  logic                  empty;
  logic                  pop;
  logic                  is_match;
  logic [PIX_W-1:0]      out_red;
  logic [PIX_W-1:0]      out_green;
  logic [PIX_W-1:0]      out_blue;
  logic                  block_valid;
  logic                  block_set;
  logic [CNT_IDX_W-1:0]  block_column;

  color_table_pixel_classifier_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .action         (action),
    .hue            (hue),
    .saturation     (saturation),
    .brightness     (brightness),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .start_of_frame (start_of_frame),
    .final_row      (final_row),
    .empty          (empty),
    .pop            (pop),
    .is_match       (is_match),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .block_valid    (block_valid),
    .block_set      (block_set),
    .block_column   (block_column)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // shared run state
  res_t             pending_results [$];  // expected result transactions, oldest first
  int unsigned      items_sent    = 0;
  int unsigned      results_seen  = 0;
  int unsigned      mismatch_count = 0;
  bit               idle_enable   = 1'b1;
  int unsigned      hold_off      = 0;    // result-side hold-off, counted down by the popper
  logic [PIX_W-1:0] pool_hue [POOL_SIZE];
  logic [PIX_W-1:0] pool_sat [POOL_SIZE];

  // behavioral copy of the classifier state
  bit               trained_bits [TABLE_SIZE];
  logic [CNT_W-1:0] block_tally [COUNTER_DEPTH];
  int unsigned      scan_column;
  int unsigned      scan_group_row;
  logic [PIX_W-1:0] win_low;
  logic [PIX_W-1:0] win_high;
  logic [FW_W-1:0]  row_width;

  function automatic bit in_window(logic [PIX_W-1:0] v);
    return v >= win_low && v <= win_high;
  endfunction

  // upper hue bits select the row, upper saturation bits the column
  function automatic int unsigned table_index(logic [PIX_W-1:0] h, logic [PIX_W-1:0] s);
    int unsigned hi_part;
    int unsigned lo_part;
    hi_part = 32'(h >> (PIX_W - HUE_BITS));
    lo_part = 32'(s >> (PIX_W - SAT_BITS));
    return ((hi_part << SAT_BITS) | lo_part) % TABLE_SIZE;
  endfunction

  // zero acts as one pixel, anything past the limit is clipped
  function automatic int unsigned effective_width();
    if (row_width == 0) return 1;
    if (row_width > WIDTH_LIMIT) return WIDTH_LIMIT;
    return 32'(row_width);
  endfunction

  // expected result of one accepted pixel; advances the behavioral state
  function automatic res_t predict_classification(pixel_t p);
    res_t        res;
    int unsigned addr;
    int unsigned bcol;
    int unsigned width;
    bit          hit;
    bit          row_done;
    bit          col_done;
    bit          group_done;
    res  = '0;
    addr = table_index(p.hue, p.sat);
    if (p.action == ACT_TRAIN) begin
      // training leaves position and counters alone, result stays all zero
      if (in_window(p.bright)) trained_bits[addr] = 1'b1;
    end else begin
      if (p.sof) begin
        scan_column    = 0;
        scan_group_row = 0;
        foreach (block_tally[i]) block_tally[i] = '0;
      end
      width = effective_width();
      hit   = trained_bits[addr] && in_window(p.bright);
      if (hit) begin
        res.is_match  = 1'b1;
        res.out_red   = p.r;
        res.out_green = p.g;
        res.out_blue  = p.b;
      end
      bcol       = scan_column / BLOCK_SIZE;
      row_done   = scan_column + 1 >= width;
      col_done   = (scan_column % BLOCK_SIZE) == BLOCK_SIZE - 1 || row_done;
      group_done = scan_group_row >= BLOCK_SIZE - 1 || p.last_row;
      if (bcol < COL_LIMIT) begin
        // counter sticks at its top value
        if (hit && block_tally[bcol] < COUNT_MAX)
          block_tally[bcol] = block_tally[bcol] + CNT_W'(1);
        if (col_done && group_done) begin
          // full-area threshold even for a narrow last block
          res.block_valid  = 1'b1;
          res.block_set    = block_tally[bcol] > BLOCK_HALF;
          res.block_column = bcol[CNT_IDX_W-1:0];
          block_tally[bcol] = '0;
        end
      end
      if (row_done) begin
        scan_column    = 0;
        scan_group_row = group_done ? 0 : (scan_group_row + 1) % (1 << RIG_W);
      end else begin
        scan_column = (scan_column + 1) % (1 << COL_W);
      end
    end
    return res;
  endfunction

  function automatic pixel_t make_pixel(action_e act, int unsigned h, int unsigned s,
                                        int unsigned v, int unsigned rr, int unsigned gg,
                                        int unsigned bb, bit sof, bit fr);
    pixel_t p;
    p.action   = act;
    p.hue      = h[PIX_W-1:0];
    p.sat      = s[PIX_W-1:0];
    p.bright   = v[PIX_W-1:0];
    p.r        = rr[PIX_W-1:0];
    p.g        = gg[PIX_W-1:0];
    p.b        = bb[PIX_W-1:0];
    p.sof      = sof;
    p.last_row = fr;
    return p;
  endfunction

  // mostly trained colors and in-window brightness so that matches are common
  function automatic pixel_t random_pixel(action_e act, bit sof, bit fr);
    pixel_t      p;
    int unsigned k;
    k = $urandom_range(POOL_SIZE - 1, 0);
    p.action = act;
    if ($urandom_range(9, 0) < 7) begin
      p.hue = pool_hue[k];
      p.sat = pool_sat[k];
    end else begin
      p.hue = PIX_W'($urandom_range(255, 0));
      p.sat = PIX_W'($urandom_range(255, 0));
    end
    if (win_low <= win_high && $urandom_range(3, 0) != 0)
      p.bright = PIX_W'($urandom_range(win_high, win_low));
    else p.bright = PIX_W'($urandom_range(255, 0));
    p.r        = PIX_W'($urandom_range(255, 0));
    p.g        = PIX_W'($urandom_range(255, 0));
    p.b        = PIX_W'($urandom_range(255, 0));
    p.sof      = sof;
    p.last_row = fr;
    return p;
  endfunction

  // one pixel transaction: optional gap, then hold push until full is low at an edge
  task automatic send_pixel(input pixel_t p);
    int unsigned gap;
    if (idle_enable && $urandom_range(7, 0) == 0) begin
      gap = $urandom_range(15, 1);
      @(negedge clk);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push           = 1'b1;
    action         = p.action;
    hue            = p.hue;
    saturation     = p.sat;
    brightness     = p.bright;
    red            = p.r;
    green          = p.g;
    blue           = p.b;
    start_of_frame = p.sof;
    final_row      = p.last_row;
    do begin
      @(posedge clk);
    end while (full !== 1'b0);
    pending_results.push_back(predict_classification(p));
    items_sent++;
  endtask

  // sender pause until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    case (idx)
      REG_INTENSITY_MIN: win_low   = cfg_data[PIX_W-1:0];
      REG_INTENSITY_MAX: win_high  = cfg_data[PIX_W-1:0];
      REG_FRAME_WIDTH:   row_width = cfg_data[FW_W-1:0];
      default: ;
    endcase
  endtask

  // all three registers, written only once the block has gone idle
  task automatic set_config(input int unsigned lo, input int unsigned hi, input int unsigned w);
    wait_drained();
    write_register(REG_INTENSITY_MIN, lo);
    write_register(REG_INTENSITY_MAX, hi);
    write_register(REG_FRAME_WIDTH, w);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // empty table, training ignores frame marks, byte extremes, black on match
  task automatic test_table_basics();
    send_pixel(make_pixel(ACT_CLASSIFY, 0, 0, 0, 255, 255, 255, 1, 0));
    send_pixel(make_pixel(ACT_TRAIN, 0, 0, 0, 255, 255, 255, 1, 1));
    send_pixel(make_pixel(ACT_TRAIN, 255, 255, 255, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 0, 0, 0, 255, 255, 255, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 255, 255, 255, 255, 255, 255, 0, 1));
    send_pixel(make_pixel(ACT_CLASSIFY, 255, 255, 255, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 255, 0, 128, 170, 85, 1, 0, 0));
  endtask

  // window edges for training and matching, then an inverted window
  task automatic test_intensity_window();
    set_config(10, 200, 2 * BLOCK_SIZE);
    send_pixel(make_pixel(ACT_TRAIN, 1, 1, 9, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(ACT_TRAIN, 2, 2, 201, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(ACT_TRAIN, 3, 3, 10, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(ACT_TRAIN, 4, 4, 200, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 1, 1, 100, 11, 22, 33, 1, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 2, 2, 100, 11, 22, 33, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 3, 3, 10, 44, 55, 66, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 4, 4, 200, 77, 88, 99, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 3, 3, 9, 44, 55, 66, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 4, 4, 201, 77, 88, 99, 0, 0));
    set_config(200, 10, 2 * BLOCK_SIZE);
    send_pixel(make_pixel(ACT_TRAIN, 5, 5, 100, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 5, 5, 100, 1, 2, 3, 0, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 0, 0, 100, 1, 2, 3, 0, 0));
  endtask

  // width zero acts as one, width past the limit is clipped; window at both ends
  task automatic test_width_limits();
    set_config(255, 255, 0);
    send_pixel(make_pixel(ACT_CLASSIFY, 255, 255, 255, 9, 8, 7, 1, 1));
    send_pixel(make_pixel(ACT_CLASSIFY, 0, 0, 50, 9, 8, 7, 0, 0));
    set_config(0, 0, (1 << FW_W) - 1);
    send_pixel(make_pixel(ACT_CLASSIFY, 0, 0, 0, 6, 5, 4, 1, 0));
    send_pixel(make_pixel(ACT_CLASSIFY, 255, 255, 255, 6, 5, 4, 0, 1));
  endtask

  // row narrower than a block: the decision falls on the row's last pixel
  task automatic test_partial_block();
    set_config(0, 255, 3);
    send_pixel(make_pixel(ACT_CLASSIFY, 0, 0, 30, 1, 1, 1, 1, 1));
    send_pixel(make_pixel(ACT_CLASSIFY, 255, 255, 31, 2, 2, 2, 0, 1));
    send_pixel(make_pixel(ACT_CLASSIFY, 0, 0, 32, 3, 3, 3, 0, 1));
  endtask

  // the second block column collects 256 matches over 32 rows; one-pixel rows
  // close each row group without touching it, so only saturation keeps the flag set
  task automatic test_counter_saturation();
    int unsigned round_idx;
    int unsigned row;
    int unsigned col;
    int unsigned rows_in_round;
    pixel_t      p;
    set_config(0, 255, 2 * BLOCK_SIZE);
    send_pixel(make_pixel(ACT_TRAIN, pool_hue[0], pool_sat[0], 128, 0, 0, 0, 0, 0));
    for (round_idx = 0; round_idx < 5; round_idx++) begin
      rows_in_round = (round_idx < 4) ? BLOCK_SIZE - 1 : 4;
      for (row = 0; row < rows_in_round; row++) begin
        for (col = 0; col < 2 * BLOCK_SIZE; col++) begin
          if (col < BLOCK_SIZE) p = random_pixel(ACT_CLASSIFY, 1'b0, 1'b0);
          else p = make_pixel(ACT_CLASSIFY, pool_hue[0], pool_sat[0], 128,
                              $urandom_range(255, 0), $urandom_range(255, 0),
                              $urandom_range(255, 0), 0, 0);
          p.sof      = (round_idx == 0 && row == 0 && col == 0);
          p.last_row = (round_idx == 4 && row == rows_in_round - 1);
          send_pixel(p);
        end
      end
      if (round_idx < 4) begin
        set_config(0, 255, 1);
        send_pixel(random_pixel(ACT_CLASSIFY, 1'b0, 1'b1));
        set_config(0, 255, 2 * BLOCK_SIZE);
      end
    end
  endtask

  // result side holds off long enough for the queues to fill and push to stall
  task automatic test_full_stall();
    int unsigned i;
    idle_enable = 1'b0;
    set_config(0, 255, 12);
    hold_off = HOLD_CYCLES;
    for (i = 0; i < 48; i++) send_pixel(random_pixel(ACT_CLASSIFY, i == 0, i >= 36));
    wait_drained();
    idle_enable = 1'b1;
  endtask

  // one setting, some training, then frames with random content and some broken marks
  task automatic run_random_phase(input int unsigned budget, input bit idle_on);
    int unsigned lo;
    int unsigned hi;
    int unsigned w;
    int unsigned w_eff;
    int unsigned rows;
    int unsigned row;
    int unsigned c;
    int unsigned sent;
    bit          sof;
    bit          fr;
    pixel_t      p;
    case ($urandom_range(4, 0))
      0: begin
        lo = 0;
        hi = 255;
      end
      1: begin
        lo = $urandom_range(255, 0);
        hi = lo;
      end
      2: begin
        hi = $urandom_range(254, 0);
        lo = $urandom_range(255, hi + 1);
      end
      default: begin
        lo = $urandom_range(128, 0);
        hi = $urandom_range(255, lo);
      end
    endcase
    case ($urandom_range(9, 0))
      0:       w = WIDTH_LIMIT;
      1:       w = (1 << FW_W) - 1;
      2:       w = 0;
      default: w = $urandom_range(5 * BLOCK_SIZE, 1);
    endcase
    set_config(lo, hi, w);
    idle_enable = idle_on;
    w_eff = effective_width();
    sent = 0;
    repeat (POOL_SIZE / 2) begin
      send_pixel(random_pixel(ACT_TRAIN, 1'($urandom_range(1, 0)),
                              1'($urandom_range(1, 0))));
      sent++;
    end
    while (sent < budget) begin
      rows = $urandom_range(12, 1);
      for (row = 0; row < rows && sent < budget; row++) begin
        for (c = 0; c < w_eff && sent < budget; c++) begin
          // stray training between classify pixels
          if ($urandom_range(9, 0) == 0) begin
            send_pixel(random_pixel(ACT_TRAIN, 1'($urandom_range(1, 0)),
                                    1'($urandom_range(1, 0))));
            sent++;
          end
          // mostly well formed marks, now and then a missing or stray one
          if (row == 0 && c == 0) sof = $urandom_range(19, 0) != 0;
          else sof = $urandom_range(49, 0) == 0;
          if (row == rows - 1) fr = $urandom_range(19, 0) != 0;
          else fr = $urandom_range(29, 0) == 0;
          p = random_pixel(ACT_CLASSIFY, sof, fr);
          send_pixel(p);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_frames();
    while (items_sent < TOTAL_ITEMS - TAIL_ITEMS)
      run_random_phase(PHASE_ITEMS, $urandom_range(3, 0) != 0);
    // last stretch with no idling on either side
    run_random_phase(TAIL_ITEMS, 1'b0);
  endtask

  // result popper: random stall bursts, plus the long hold-off when asked
  initial begin : result_side
    int unsigned stall;
    stall = 0;
    pop   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off != 0) begin
        pop = 1'b0;
        hold_off--;
      end else if (stall != 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        if (idle_enable && $urandom_range(7, 0) == 0) stall = $urandom_range(15, 1);
      end
    end
  end

  // every popped result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && pop === 1'b1 && empty === 1'b0) begin
      got = {is_match, out_red, out_green, out_blue, block_valid, block_set, block_column};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        want = pending_results.pop_front();
        if (got.is_match !== want.is_match || got.out_red !== want.out_red ||
            got.out_green !== want.out_green || got.out_blue !== want.out_blue ||
            got.block_valid !== want.block_valid || got.block_set !== want.block_set ||
            got.block_column !== want.block_column) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d: expected m%0b rgb %h %h %h blk %0b/%0b/%0d,",
                     results_seen, want.is_match, want.out_red, want.out_green,
                     want.out_blue, want.block_valid, want.block_set, want.block_column,
                     " got m%0b rgb %h %h %h blk %0b/%0b/%0d",
                     got.is_match, got.out_red, got.out_green, got.out_blue,
                     got.block_valid, got.block_set, got.block_column);
        end
      end
    end
  end

  // run limit, with room for the table clearing after reset
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_color_table_pixel_classifier_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    push           = 1'b0;
    action         = ACT_CLASSIFY;
    hue            = '0;
    saturation     = '0;
    brightness     = '0;
    red            = '0;
    green          = '0;
    blue           = '0;
    start_of_frame = 1'b0;
    final_row      = 1'b0;
    // behavioral state after reset
    foreach (trained_bits[i]) trained_bits[i] = 1'b0;
    foreach (block_tally[i]) block_tally[i] = '0;
    scan_column    = 0;
    scan_group_row = 0;
    win_low        = '0;
    win_high       = 8'd255;
    row_width      = DEFAULT_WIDTH;
    foreach (pool_hue[i]) begin
      pool_hue[i] = PIX_W'($urandom_range(255, 0));
      pool_sat[i] = PIX_W'($urandom_range(255, 0));
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_table_basics();
    test_intensity_window();
    test_width_limits();
    test_partial_block();
    test_counter_saturation();
    test_full_stall();
    test_random_frames();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_color_table_pixel_classifier_top OK");
    end else begin
      $display("tb_color_table_pixel_classifier_top NOT OK");
    end
    $finish;
  end

endmodule
